// ----- hw/rtl/tng_pkg.sv -----
// shared types and constants of the triangle normal generator
package tng_pkg;

	// index width of every vertex field
	localparam int IDX_W = 10;
	// width of a cross product component and of the normalizer input
	localparam int VEC_W = 35;
	// accumulator component width
	localparam int ACC_W = 24;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [ACC_W:0] ACC_MAX = 25'sd8388607;
	localparam logic signed [ACC_W:0] ACC_MIN = -25'sd8388608;

	// item commands
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_TRI   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic {
		REG_PER_VERTEX = 1'b0,
		REG_CCW        = 1'b1
	} reg_idx_t;

	// result kinds
	localparam logic KIND_FACE   = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	// normalizer status
	typedef struct packed {
		logic done;
		logic nonzero;
	} norm_stat_t;

endpackage

// ----- hw/rtl/triangle_normal_generator_unit.sv -----
// top level of the triangle normal generator
// Position loads are written as they are accepted. A triangle reads its three positions, forms
// the cross product and normalizes it in the shared iterative normalizer, which squares, takes
// a 31-step integer root and divides 15 bits per component; in vertex mode three accumulator
// read-modify-writes follow. A vertex read normalizes its accumulator entry in the same
// normalizer. After reset and after a clear item the accumulator memory is swept one entry
// per cycle over min(VERTICES,1024) entries, with no item accepted; configuration writes are
// taken at any time.
module triangle_normal_generator_unit import tng_pkg::*; #(
	parameter int VERTICES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [0:0]         cfg_index,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [IDX_W-1:0]   index_a,
	input  logic [IDX_W-1:0]   index_b,
	input  logic [IDX_W-1:0]   index_c,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               result_kind
);

	localparam int DEPTH = (VERTICES < (1 << IDX_W)) ? VERTICES : (1 << IDX_W);
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_CLEAR  = 10'b0000000010,
		S_POS    = 10'b0000000100,
		S_CROSS  = 10'b0000001000,
		S_NORM   = 10'b0000010000,
		S_EMIT   = 10'b0000100000,
		S_ACC_RD = 10'b0001000000,
		S_ACC_WR = 10'b0010000000,
		S_RDA    = 10'b0100000000,
		S_RDB    = 10'b1000000000
	} state_t;

	state_t             state_q;
	logic               pvm_q;
	logic               ccw_q;
	logic [AW-1:0]      clr_q;
	logic [1:0]         cnt_q;
	logic               read_q;
	logic               go_q;
	logic [IDX_W-1:0]   idx_q [3];
	logic               ok_q [3];
	logic signed [15:0] pv_q [3][3];
	logic signed [16:0] u_q [3];
	logic signed [16:0] v_q [3];
	logic signed [VEC_W-1:0] vec_q [3];
	logic signed [15:0] n_q [3];
	logic               out_valid_q;
	logic signed [15:0] out_n_q [3];
	logic               out_kind_q;

	logic               accept;
	logic               pos_we;
	logic [AW-1:0]      pos_raddr;
	logic [47:0]        pos_rdata;
	logic               acc_we;
	logic [AW-1:0]      acc_waddr;
	logic [AW-1:0]      acc_raddr;
	logic [71:0]        acc_wdata;
	logic [71:0]        acc_rdata;
	logic               in_ok;
	logic signed [16:0] ma, mb, mc, md;
	logic signed [VEC_W-1:0] xprod;
	norm_stat_t         nstat;
	logic signed [15:0] nrm [3];
	logic signed [15:0] nf [3];

	function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
		logic signed [15:0] b);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
		if (s > ACC_MAX)      return ACC_MAX[ACC_W-1:0];
		else if (s < ACC_MIN) return ACC_MIN[ACC_W-1:0];
		else                  return s[ACC_W-1:0];
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_ok    = 32'(index_a) < VERTICES;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvm_q <= 1'b1;
			ccw_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PER_VERTEX: pvm_q <= cfg_wdata;
				REG_CCW:        ccw_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// position store, written straight from an accepted load
	assign pos_we    = accept && (cmd == CMD_LOAD) && in_ok;
	assign pos_raddr = idx_q[cnt_q][AW-1:0];

	tng_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (index_a[AW-1:0]),
		.wdata ({pos_x, pos_y, pos_z}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// accumulator store: clearing sweep or one read-modify-write at a time
	always_comb begin
		acc_raddr = (state_q == S_RDA) ? idx_q[0][AW-1:0] : idx_q[cnt_q][AW-1:0];
		if (state_q == S_CLEAR) begin
			acc_we    = 1'b1;
			acc_waddr = clr_q;
			acc_wdata = '0;
		end else begin
			acc_we    = (state_q == S_ACC_WR) && ok_q[cnt_q];
			acc_waddr = idx_q[cnt_q][AW-1:0];
			acc_wdata = {sat_add(acc_rdata[71:48], n_q[0]),
				sat_add(acc_rdata[47:24], n_q[1]),
				sat_add(acc_rdata[23:0], n_q[2])};
		end
	end

	tng_ram #(.WIDTH(72), .DEPTH(DEPTH)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// cross product operands, one component per cycle
	always_comb begin
		case (cnt_q)
			2'd1: begin ma = u_q[1]; mb = v_q[2]; mc = u_q[2]; md = v_q[1]; end
			2'd2: begin ma = u_q[2]; mb = v_q[0]; mc = u_q[0]; md = v_q[2]; end
			default: begin ma = u_q[0]; mb = v_q[1]; mc = u_q[1]; md = v_q[0]; end
		endcase
		xprod = VEC_W'(ma * mb) - VEC_W'(mc * md);
	end

	tng_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.vec_x  (vec_q[0]),
		.vec_y  (vec_q[1]),
		.vec_z  (vec_q[2]),
		.stat   (nstat),
		.nrm_x  (nrm[0]),
		.nrm_y  (nrm[1]),
		.nrm_z  (nrm[2])
	);

	// face normal fixups: default direction in face mode, winding
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nf[k] = nrm[k];
		end
		if (!read_q) begin
			if (!pvm_q && !nstat.nonzero) begin
				nf[0] = ONE_Q14;
				nf[1] = '0;
				nf[2] = '0;
			end
			if (!ccw_q) begin
				for (int k = 0; k < 3; k++) begin
					nf[k] = -nf[k];
				end
			end
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= (state_q == S_CROSS && cnt_q == 2'd3) || (state_q == S_RDB);
			if (state_q == S_EMIT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (cmd)
							CMD_TRI:   state_q <= S_POS;
							CMD_READ:  state_q <= S_RDA;
							CMD_CLEAR: state_q <= S_CLEAR;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_POS: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_CROSS;
					end
				end
				S_CROSS: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_NORM;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_NORM;
				S_NORM: begin
					cnt_q <= '0;
					if (nstat.done) begin
						state_q <= (read_q || !pvm_q) ? S_EMIT : S_ACC_RD;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					cnt_q   <= cnt_q + 2'd1;
					state_q <= (cnt_q == 2'd2) ? S_IDLE : S_ACC_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q[0] <= index_a;
			idx_q[1] <= index_b;
			idx_q[2] <= index_c;
			ok_q[0]  <= in_ok;
			ok_q[1]  <= 32'(index_b) < VERTICES;
			ok_q[2]  <= 32'(index_c) < VERTICES;
			read_q   <= (cmd == CMD_READ);
		end
		// capture positions one read behind the address
		if (state_q == S_POS && cnt_q != 2'd0) begin
			pv_q[cnt_q - 2'd1][0] <= ok_q[cnt_q - 2'd1] ? pos_rdata[47:32] : '0;
			pv_q[cnt_q - 2'd1][1] <= ok_q[cnt_q - 2'd1] ? pos_rdata[31:16] : '0;
			pv_q[cnt_q - 2'd1][2] <= ok_q[cnt_q - 2'd1] ? pos_rdata[15:0]  : '0;
		end
		if (state_q == S_CROSS) begin
			if (cnt_q == 2'd0) begin
				for (int k = 0; k < 3; k++) begin
					u_q[k] <= 17'(pv_q[1][k]) - 17'(pv_q[0][k]);
					v_q[k] <= 17'(pv_q[2][k]) - 17'(pv_q[1][k]);
				end
			end else begin
				vec_q[cnt_q - 2'd1] <= xprod;
			end
		end
		if (state_q == S_RDB) begin
			vec_q[0] <= ok_q[0] ? VEC_W'($signed(acc_rdata[71:48])) : '0;
			vec_q[1] <= ok_q[0] ? VEC_W'($signed(acc_rdata[47:24])) : '0;
			vec_q[2] <= ok_q[0] ? VEC_W'($signed(acc_rdata[23:0]))  : '0;
		end
		if (state_q == S_NORM && nstat.done) begin
			for (int k = 0; k < 3; k++) begin
				n_q[k] <= nf[k];
			end
		end
		// output register loads as the result transfer slot frees up
		if (state_q == S_EMIT && (!out_valid_q || out_ready)) begin
			for (int k = 0; k < 3; k++) begin
				out_n_q[k] <= n_q[k];
			end
			out_kind_q <= read_q ? KIND_VERTEX : KIND_FACE;
		end
	end

	assign out_valid   = out_valid_q;
	assign normal_x    = out_n_q[0];
	assign normal_y    = out_n_q[1];
	assign normal_z    = out_n_q[2];
	assign result_kind = out_kind_q;

	// a load finishes in the cycle it is accepted
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_LOAD) |=> (state_q == S_IDLE))
		else $error("load did not complete in one cycle");

	// a waiting result is never overwritten
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && !out_ready) |=> (state_q == S_EMIT))
		else $error("result overwritten while waiting");

	// accumulation only in vertex mode and only after a triangle
	a_acc_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC_WR) |-> (pvm_q && !read_q))
		else $error("accumulator updated outside vertex mode");

	// the normalizer is only started while no item is accepted
	a_norm_start: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> (state_q == S_NORM && !in_ready))
		else $error("normalizer started outside its state");

endmodule

// ----- hw/rtl/tng_ram.sv -----
// generic simple dual port ram with registered read
module tng_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/tng_norm.sv -----
// iterative vector normalizer to signed q1.14 (square, root, divide)
module tng_norm import tng_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VEC_W-1:0] vec_x,
	input  logic signed [VEC_W-1:0] vec_y,
	input  logic signed [VEC_W-1:0] vec_z,
	output norm_stat_t              stat,
	output logic signed [15:0]      nrm_x,
	output logic signed [15:0]      nrm_y,
	output logic signed [15:0]      nrm_z
);

	typedef enum logic [3:0] {
		N_IDLE = 4'b0001,
		N_SQ   = 4'b0010,
		N_ROOT = 4'b0100,
		N_DIV  = 4'b1000
	} nstate_t;

	nstate_t            state_q;
	logic [29:0]        m_q [3];
	logic               neg_q [3];
	logic [1:0]         cnt_q;
	logic [59:0]        prod_q;
	logic [61:0]        sum_q;
	logic [61:0]        res_q;
	logic [4:0]         j_q;
	logic [30:0]        len_q;
	logic [3:0]         dcnt_q;
	logic [31:0]        rem_q;
	logic [14:0]        lo_q;
	logic [14:0]        q_q;
	logic               done_q;
	logic               nz_q;
	logic signed [15:0] n_q [3];

	logic [VEC_W-1:0] mag [3];
	logic [VEC_W-1:0] mx;
	logic [2:0]       sh;
	logic [61:0]      bitv;
	logic [61:0]      trial;
	logic [46:0]      num;
	logic [31:0]      dvs;
	logic [32:0]      part;
	logic             ge;
	logic [14:0]      qf;
	logic [15:0]      qs;

	// magnitudes and the shift that brings them below 2^30
	always_comb begin
		mag[0] = vec_x[VEC_W-1] ? VEC_W'(-vec_x) : VEC_W'(vec_x);
		mag[1] = vec_y[VEC_W-1] ? VEC_W'(-vec_y) : VEC_W'(vec_y);
		mag[2] = vec_z[VEC_W-1] ? VEC_W'(-vec_z) : VEC_W'(vec_z);
		mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
		if (mag[2] > mx) begin
			mx = mag[2];
		end
		if (mx[34])      sh = 3'd5;
		else if (mx[33]) sh = 3'd4;
		else if (mx[32]) sh = 3'd3;
		else if (mx[31]) sh = 3'd2;
		else if (mx[30]) sh = 3'd1;
		else             sh = 3'd0;
	end

	// one root digit and one quotient bit per cycle
	always_comb begin
		bitv  = 62'(1) << {j_q, 1'b0};
		trial = res_q + bitv;
		num   = {m_q[cnt_q], 15'b0} + 47'(len_q);
		dvs   = {len_q, 1'b0};
		part  = {rem_q, lo_q[14]};
		ge    = part >= {1'b0, dvs};
		qf    = {q_q[13:0], ge};
		qs    = neg_q[cnt_q] ? 16'(-{1'b0, qf}) : {1'b0, qf};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= (state_q == N_DIV) &&
				((len_q == '0) || (dcnt_q == 4'd15 && cnt_q == 2'd2));
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_SQ;
						cnt_q   <= '0;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= N_ROOT;
					end
				end
				N_ROOT: begin
					if (j_q == 5'd0) begin
						state_q <= N_DIV;
						cnt_q   <= '0;
					end
				end
				N_DIV: begin
					if (len_q == '0) begin
						state_q <= N_IDLE;
					end else if (dcnt_q == 4'd15) begin
						cnt_q <= cnt_q + 2'd1;
						if (cnt_q == 2'd2) begin
							state_q <= N_IDLE;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int k = 0; k < 3; k++) begin
						m_q[k] <= 30'(mag[k] >> sh);
					end
					neg_q[0] <= vec_x[VEC_W-1];
					neg_q[1] <= vec_y[VEC_W-1];
					neg_q[2] <= vec_z[VEC_W-1];
					sum_q    <= '0;
				end
			end
			N_SQ: begin
				if (cnt_q != 2'd3) begin
					prod_q <= m_q[cnt_q] * m_q[cnt_q];
				end
				if (cnt_q != 2'd0) begin
					sum_q <= sum_q + 62'(prod_q);
				end
				res_q <= '0;
				j_q   <= 5'd30;
			end
			N_ROOT: begin
				if (sum_q >= trial) begin
					sum_q <= sum_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
				j_q    <= j_q - 5'd1;
				dcnt_q <= '0;
				if (j_q == 5'd0) begin
					len_q <= (sum_q >= trial) ? 31'((res_q >> 1) + bitv) : 31'(res_q >> 1);
				end
			end
			N_DIV: begin
				if (len_q == '0) begin
					nz_q <= 1'b0;
					for (int k = 0; k < 3; k++) begin
						n_q[k] <= '0;
					end
				end else if (dcnt_q == 4'd0) begin
					rem_q  <= num[46:15];
					lo_q   <= num[14:0];
					q_q    <= '0;
					dcnt_q <= 4'd1;
					nz_q   <= 1'b1;
				end else begin
					rem_q  <= ge ? 32'(part - {1'b0, dvs}) : part[31:0];
					lo_q   <= {lo_q[13:0], 1'b0};
					q_q    <= qf;
					dcnt_q <= (dcnt_q == 4'd15) ? 4'd0 : dcnt_q + 4'd1;
					if (dcnt_q == 4'd15) begin
						n_q[cnt_q] <= qs;
					end
				end
			end
			default: ;
		endcase
	end

	assign stat.done    = done_q;
	assign stat.nonzero = nz_q;
	assign nrm_x        = n_q[0];
	assign nrm_y        = n_q[1];
	assign nrm_z        = n_q[2];

	// a unit component never exceeds one in magnitude
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (nrm_x <= ONE_Q14 && nrm_x >= -ONE_Q14 &&
			nrm_y <= ONE_Q14 && nrm_y >= -ONE_Q14 &&
			nrm_z <= ONE_Q14 && nrm_z >= -ONE_Q14))
		else $error("normal component out of range");

	// a zero result is all zero
	a_norm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && !stat.nonzero) |-> (nrm_x == 0 && nrm_y == 0 && nrm_z == 0))
		else $error("zero vector gave nonzero normal");

endmodule
